// ----- rtl/core/bstk_pkg.sv -----
// Shared types, result codes and width helpers for the bounded stack core.
// Used by every module under rtl/core and by the port checker.
package bstk_pkg;

	localparam int unsigned DEFAULT_DEPTH = 16;
	localparam int unsigned WORD_W        = 32;

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP     = 3'd1,
		CMD_PEEK    = 3'd2,
		CMD_PAL     = 3'd3,
		CMD_DISPLAY = 3'd4
	} cmd_e;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [WORD_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [1:0]               status;
		logic                     is_palindrome;
		logic                     last;
	} rsp_t;

	typedef enum logic [2:0] {
		SEL_PUSH_OK,
		SEL_OVERFLOW,
		SEL_EMPTY,
		SEL_DATA,
		SEL_PAL_TRUE,
		SEL_PAL_FALSE
	} rsp_sel_e;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     start;
		logic     start_top;
		logic     push;
		logic     pop;
		logic     step_lo;
		logic     step_hi;
		logic     emit;
		rsp_sel_e sel;
		logic     last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic short_fill;
		logic out_free;
		logic match;
		logic span_le2;
		logic at_top;
	} dp_stat_t;

	function automatic int unsigned addr_w(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int unsigned cnt_w(input int unsigned depth);
		return $clog2(depth + 1);
	endfunction

endpackage

// ----- rtl/core/bstk_ram.sv -----
// Generic RAM: one write port and two read ports with registered read data.
// Depends only on bstk_pkg for the address width helper and the default sizes.
module bstk_ram #(
	parameter int unsigned WIDTH = bstk_pkg::WORD_W,
	parameter int unsigned DEPTH = bstk_pkg::DEFAULT_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [bstk_pkg::addr_w(DEPTH)-1:0]     waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [bstk_pkg::addr_w(DEPTH)-1:0]     raddr_a,
	input  logic [bstk_pkg::addr_w(DEPTH)-1:0]     raddr_b,
	output logic [WIDTH-1:0]                       rdata_a,
	output logic [WIDTH-1:0]                       rdata_b
);
	import bstk_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- rtl/core/bstk_dp.sv -----
// Datapath of the stack core: fill count, walk pointers, storage RAM and
// the result register. Depends on bstk_pkg and bstk_ram.
module bstk_dp #(
	parameter int unsigned DEPTH = bstk_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bstk_pkg::req_t     req,
	input  bstk_pkg::dp_cmd_t  cmd,
	output bstk_pkg::dp_stat_t stat,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output bstk_pkg::rsp_t     rsp
);
	import bstk_pkg::*;

	localparam int unsigned AW = addr_w(DEPTH);
	localparam int unsigned CW = cnt_w(DEPTH);

	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     fill_m1;
	logic [AW-1:0]     top_idx;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [AW-1:0]     span;
	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	rsp_t              rsp_next;

	assign fill_m1 = fill_q - CW'(1);
	assign top_idx = fill_m1[AW-1:0];
	assign span    = hi_q - lo_q;

	bstk_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.push),
		.waddr   (fill_q[AW-1:0]),
		.wdata   (req.push_value),
		.raddr_a (lo_q),
		.raddr_b (hi_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		stat.empty      = (fill_q == '0);
		stat.full       = (fill_q == CW'(DEPTH));
		stat.short_fill = (fill_q <= CW'(1));
		stat.out_free   = !rsp_valid_q || !rsp_stall;
		stat.match      = (rd_a == rd_b);
		stat.span_le2   = ((AW+2)'(span) <= (AW+2)'(2));
		stat.at_top     = (lo_q == hi_q);
	end

	always_comb begin
		rsp_next               = '0;
		rsp_next.last          = cmd.last;
		unique case (cmd.sel)
			SEL_PUSH_OK:   rsp_next.status = ST_OK;
			SEL_OVERFLOW:  rsp_next.status = ST_OVERFLOW;
			SEL_EMPTY:     rsp_next.status = ST_EMPTY;
			SEL_DATA:      rsp_next.data   = rd_a;
			SEL_PAL_TRUE:  rsp_next.is_palindrome = 1'b1;
			SEL_PAL_FALSE: rsp_next.is_palindrome = 1'b0;
			default:       rsp_next.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.pop) begin
				fill_q <= fill_m1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Walk pointers and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q <= cmd.start_top ? top_idx : '0;
			hi_q <= top_idx;
		end else begin
			if (cmd.step_lo) begin
				lo_q <= lo_q + AW'(1);
			end
			if (cmd.step_hi) begin
				hi_q <= hi_q - AW'(1);
			end
		end
		if (cmd.emit) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/bstk_ctrl.sv -----
// Controller of the stack core: decodes each command and sequences reads,
// the palindrome walk and the display walk. Depends on bstk_pkg.
module bstk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic [2:0]         req_cmd,
	output logic               req_stall,
	input  bstk_pkg::dp_stat_t stat,
	output bstk_pkg::dp_cmd_t  cmd
);
	import bstk_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_EVAL
	} state_t;

	state_t state_q, state_d;
	cmd_e   op_q, op_d;
	logic   accept;

	assign req_stall = !(state_q == S_IDLE && stat.out_free);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.sel = SEL_PUSH_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_cmd) inside
						CMD_PUSH: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							cmd.sel  = stat.full ? SEL_OVERFLOW : SEL_PUSH_OK;
							cmd.push = !stat.full;
						end
						CMD_POP, CMD_PEEK, CMD_DISPLAY: begin
							if (stat.empty) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.sel  = SEL_EMPTY;
							end else begin
								cmd.start     = 1'b1;
								cmd.start_top = (req_cmd != CMD_DISPLAY);
								op_d          = cmd_e'(req_cmd);
								state_d       = S_ADDR;
							end
						end
						CMD_PAL: begin
							// Zero or one entry always reads the same both ways.
							if (stat.short_fill) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.sel  = SEL_PAL_TRUE;
							end else begin
								cmd.start = 1'b1;
								op_d      = CMD_PAL;
								state_d   = S_ADDR;
							end
						end
						default: ;
					endcase
				end
			end
			S_ADDR: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				unique case (op_q) inside
					CMD_POP, CMD_PEEK: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							cmd.sel  = SEL_DATA;
							cmd.pop  = (op_q == CMD_POP);
							state_d  = S_IDLE;
						end
					end
					CMD_PAL: begin
						if (!stat.match || stat.span_le2) begin
							if (stat.out_free) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.sel  = stat.match ? SEL_PAL_TRUE : SEL_PAL_FALSE;
								state_d  = S_IDLE;
							end
						end else begin
							cmd.step_lo = 1'b1;
							cmd.step_hi = 1'b1;
							state_d     = S_ADDR;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.last = stat.at_top;
							cmd.sel  = SEL_DATA;
							if (stat.at_top) begin
								state_d = S_IDLE;
							end else begin
								cmd.step_lo = 1'b1;
								state_d     = S_ADDR;
							end
						end
					end
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= CMD_PUSH;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

endmodule

// ----- rtl/core/bounded_stack_with_palindrome_check_core.sv -----
// Bounded LIFO stack with palindrome check. Push, and any command that finds
// the stack empty, full or too short, registers its result in the cycle after
// the transfer and takes a new command every cycle unless the result stalls.
// Pop, peek, each compared pair of the palindrome walk and each entry of the
// display walk pass through the address and evaluate states (registered RAM read).
// Reset (arst_n low) empties the stack and drops any pending result.
module bounded_stack_with_palindrome_check_core #(
	parameter int unsigned STACK_DEPTH = bstk_pkg::DEFAULT_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bstk_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bstk_pkg::rsp_t rsp
);
	import bstk_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	bstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	bstk_dp #(
		.DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/bstk_chk.sv -----
// Port-level checker for the stack core, bound to the top level below.
// Depends on bstk_pkg for the payload types and result codes.
module bstk_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input bstk_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bstk_pkg::rsp_t rsp
);
	import bstk_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_OVERFLOW ||
			rsp.status == ST_EMPTY)
		else $error("result status code out of range");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.data == '0 && rsp.last &&
			!rsp.is_palindrome)
		else $error("error result carries data or is not final");

	a_pal_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_palindrome |-> rsp.status == ST_OK && rsp.last &&
			rsp.data == '0)
		else $error("palindrome result malformed");

endmodule

bind bounded_stack_with_palindrome_check_core bstk_chk u_bstk_chk (.*);

// ----- dv/bounded_stack_with_palindrome_check_core_test.sv -----
// Self-checking testbench for the bounded stack core: drives commands with random
// gaps and stalls, predicts every result and compares it field by field.
// Depends on bstk_pkg and the RTL top bounded_stack_with_palindrome_check_core.
module bounded_stack_with_palindrome_check_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bstk_pkg::*;

	localparam int unsigned DEPTH        = DEFAULT_DEPTH;
	localparam int unsigned RANDOM_ITEMS = 470;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 4 * DEPTH + 20;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam logic [2:0]  FIRST_UNUSED_CMD = 3'd5;

	// Keeps its own copy of the stack and queues the results each command should produce.
	class stack_scoreboard;
		logic signed [WORD_W-1:0] words [DEPTH];
		int unsigned fill;
		rsp_t pending [$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void queue_result(logic signed [WORD_W-1:0] d, logic [1:0] st, logic pal,
			logic lst);
			rsp_t e;
			e.data = d;
			e.status = st;
			e.is_palindrome = pal;
			e.last = lst;
			pending.push_back(e);
		endfunction

		function void note_request(req_t r);
			logic sym;
			case (r.cmd)
				CMD_PUSH: begin
					if (fill >= DEPTH) begin
						queue_result('0, ST_OVERFLOW, 1'b0, 1'b1);
					end else begin
						words[fill] = r.push_value;
						fill++;
						queue_result('0, ST_OK, 1'b0, 1'b1);
					end
				end
				CMD_POP: begin
					if (fill == 0) begin
						queue_result('0, ST_EMPTY, 1'b0, 1'b1);
					end else begin
						queue_result(words[fill-1], ST_OK, 1'b0, 1'b1);
						fill--;
					end
				end
				CMD_PEEK: begin
					if (fill == 0)
						queue_result('0, ST_EMPTY, 1'b0, 1'b1);
					else
						queue_result(words[fill-1], ST_OK, 1'b0, 1'b1);
				end
				CMD_PAL: begin
					// An empty stack reads the same both ways.
					sym = 1'b1;
					for (int i = 0; i < fill / 2; i++)
						if (words[i] !== words[fill-1-i])
							sym = 1'b0;
					queue_result('0, ST_OK, sym, 1'b1);
				end
				CMD_DISPLAY: begin
					if (fill == 0) begin
						queue_result('0, ST_EMPTY, 1'b0, 1'b1);
					end else begin
						for (int i = 0; i < fill; i++)
							queue_result(words[i], ST_OK, 1'b0, i == fill - 1);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: unexpected result data=%0d st=%0d pal=%0b last=%0b",
						$time, got.data, got.status, got.is_palindrome, got.last);
				mismatches++;
			end else begin
				e = pending.pop_front();
				if (got.data !== e.data || got.status !== e.status ||
					got.is_palindrome !== e.is_palindrome || got.last !== e.last) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: mismatch got data=%0d st=%0d pal=%0b last=%0b, wanted data=%0d st=%0d pal=%0b last=%0b",
							$time, got.data, got.status, got.is_palindrome, got.last,
							e.data, e.status, e.is_palindrome, e.last);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	stack_scoreboard sb = new();
	int unsigned issued;
	logic req_burst;
	logic rsp_burst;

	bounded_stack_with_palindrome_check_core #(
		.STACK_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 6))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3, 4: return $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// One command transfer; valid is only lowered when a gap precedes the command.
	task automatic send_cmd(logic [2:0] code, logic signed [WORD_W-1:0] value);
		req_t r;
		int gap;
		r.cmd = code;
		r.push_value = value;
		gap = req_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(r);
		if (code <= CMD_DISPLAY)
			issued++;
	endtask

	task automatic random_run(int n, int push_pct);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_cmd(FIRST_UNUSED_CMD + 3'($urandom_range(0, 2)), $urandom());
			end else if (pick < 3 + push_pct) begin
				send_cmd(CMD_PUSH, pick_word());
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_cmd(CMD_POP, $urandom());
					4, 5: send_cmd(CMD_PEEK, $urandom());
					6, 7: send_cmd(CMD_PAL, $urandom());
					default: send_cmd(CMD_DISPLAY, $urandom());
				endcase
			end
		end
	endtask

	// Empties the stack, then builds a mirrored sequence, sometimes with one
	// bit flipped, and checks it.
	task automatic mirror_run();
		logic signed [WORD_W-1:0] vals [DEPTH];
		int k;
		int j;
		while (sb.fill > 0)
			send_cmd(CMD_POP, $urandom());
		k = $urandom_range(0, DEPTH);
		for (int i = 0; i < (k + 1) / 2; i++) begin
			vals[i] = pick_word();
			vals[k-1-i] = vals[i];
		end
		if (k > 1 && $urandom_range(0, 2) == 0) begin
			j = $urandom_range(0, k - 1);
			vals[j] = vals[j] ^ (32'sh1 << $urandom_range(0, 31));
		end
		for (int i = 0; i < k; i++)
			send_cmd(CMD_PUSH, vals[i]);
		send_cmd(CMD_PAL, $urandom());
		if ($urandom_range(0, 1) == 1)
			send_cmd(CMD_DISPLAY, $urandom());
		if (k == DEPTH)
			send_cmd(CMD_PUSH, pick_word());
	endtask

	initial begin
		logic signed [WORD_W-1:0] pattern [8];
		int idx;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		req_burst = 1'b0;
		issued = 0;
		pattern = '{32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd0,
			32'sh55555555, 32'shAAAAAAAA, 32'sd1, 32'sh12345678};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack cases and the unused command codes.
		send_cmd(CMD_PEEK, '0);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_DISPLAY, '0);
		send_cmd(CMD_PAL, '0);
		for (int i = 0; i < 3; i++)
			send_cmd(FIRST_UNUSED_CMD + 3'(i), -32'sd1);
		// Fill to the top with a mirrored pattern of extreme words, then overflow.
		for (int i = 0; i < DEPTH; i++) begin
			idx = (i < DEPTH / 2) ? i : DEPTH - 1 - i;
			send_cmd(CMD_PUSH, pattern[idx % 8]);
		end
		send_cmd(CMD_PAL, '0);
		send_cmd(CMD_PUSH, 32'sh7FFFFFFF);
		send_cmd(CMD_DISPLAY, '0);
		send_cmd(CMD_PEEK, '0);
		send_cmd(CMD_POP, '0);

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			req_burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: mirror_run();
				1: random_run($urandom_range(10, 30), 15);
				2: random_run($urandom_range(10, 30), 45);
				default: random_run($urandom_range(10, 30), 80);
			endcase
		end
		req_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int hold;
		int taken;
		rsp_stall <= 1'b0;
		rsp_burst = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 32 == 0)
				rsp_burst = ($urandom_range(0, 3) == 0);
			hold = rsp_burst ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (rsp_valid !== 1'b1);
			sb.check_response(rsp);
			taken++;
		end
	end

	// Ends the run when neither channel has moved a transfer for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0))
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/bstk_pkg.sv
rtl/core/bstk_ram.sv
rtl/core/bstk_dp.sv
rtl/core/bstk_ctrl.sv
rtl/core/bounded_stack_with_palindrome_check_core.sv
rtl/core/bstk_chk.sv
dv/bounded_stack_with_palindrome_check_core_test.sv
